// File: design/hrgb_pkg.sv
// ----------------------------------------------------------------------------
// hrgb_pkg
// Shared types and constants of the HSV to RGB LED color converter.
// ----------------------------------------------------------------------------
package hrgb_pkg;

    // Field widths of the request and the result.
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int LEVEL_W = 8;

    // Saturation limits of the inputs.
    localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Internal widths: V*S fits 14 bits, any scaled fraction (max 600000) fits 20.
    localparam int VS_W    = 14;
    localparam int WT_W    = 6;
    localparam int SCALE_W = 20;
    localparam int PROD_W  = 24;
    localparam int DIV_W   = 18;
    localparam int RECIP_W = 19;
    localparam int QPROD_W = DIV_W + RECIP_W;

    // Scale constants: 1.0 is 600000, chroma is V*S*60, V alone is V*6000.
    localparam logic [SCALE_W-1:0] SECTOR_DEG = 20'd60;
    localparam logic [SCALE_W-1:0] V_SCALE    = 20'd6000;

    // Level = floor(val * 255 / 600000) = floor(floor(val * 17 / 64) / 625).
    // The division by 625 is a multiply by ceil(2^28 / 625), exact for any
    // dividend below 2^18.
    localparam logic [PROD_W-1:0]  LEVEL_MUL   = 24'd17;
    localparam int                 PRE_SHIFT   = 6;
    localparam logic [RECIP_W-1:0] RECIP_625   = 19'd429497;
    localparam int                 RECIP_SHIFT = 28;

    // Hue sector, named by the channel that carries chroma and the secondary.
    typedef enum logic [2:0] {
        SEC_R_G = 3'd0,     // 0..59:    red = C, green = X
        SEC_G_R = 3'd1,     // 60..119:  green = C, red = X
        SEC_G_B = 3'd2,     // 120..179: green = C, blue = X
        SEC_B_G = 3'd3,     // 180..239: blue = C, green = X
        SEC_B_R = 3'd4,     // 240..299: blue = C, red = X
        SEC_R_B = 3'd5      // 300..360: red = C, blue = X
    } sector_t;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic             lamp_on;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] bright;
        logic [WT_W-1:0]  weight;   // 60 - |(H mod 120) - 60|
        sector_t          sector;
    } work_t;

endpackage

// File: design/hrgb_front.sv
// ----------------------------------------------------------------------------
// hrgb_front
// Accepts requests, saturates the fields and classifies the hue into its
// sector and the triangle-wave weight of the secondary component.
// ----------------------------------------------------------------------------
module hrgb_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         lamp_on,
    input  logic [hrgb_pkg::HUE_W-1:0]   hue_deg,
    input  logic [hrgb_pkg::PCT_W-1:0]   saturation_pct,
    input  logic [hrgb_pkg::PCT_W-1:0]   brightness_pct,
    output logic                         push_valid,
    input  logic                         push_ready,
    output hrgb_pkg::work_t              push_item
);
    import hrgb_pkg::*;

    logic             vld_reg;
    logic             vld_next;
    work_t            item_reg;
    work_t            item_next;

    logic [HUE_W-1:0] hue_sat;
    logic [PCT_W-1:0] sat_sat;
    logic [PCT_W-1:0] bright_sat;
    logic [HUE_W-1:0] base;
    logic [WT_W-1:0]  offset;
    sector_t          sector;
    logic             odd_sector;
    logic             take;

    // Saturate the fields to their ranges.
    always_comb
    begin
        hue_sat    = (hue_deg > HUE_MAX) ? HUE_MAX : hue_deg;
        sat_sat    = (saturation_pct > PCT_MAX) ? PCT_MAX : saturation_pct;
        bright_sat = (brightness_pct > PCT_MAX) ? PCT_MAX : brightness_pct;
    end

    // Pick the sector and the start angle of that sector.
    always_comb
    begin
        priority if (hue_sat < 9'd60)
        begin
            sector = SEC_R_G;
            base   = 9'd0;
        end
        else if (hue_sat < 9'd120)
        begin
            sector = SEC_G_R;
            base   = 9'd60;
        end
        else if (hue_sat < 9'd180)
        begin
            sector = SEC_G_B;
            base   = 9'd120;
        end
        else if (hue_sat < 9'd240)
        begin
            sector = SEC_B_G;
            base   = 9'd180;
        end
        else if (hue_sat < 9'd300)
        begin
            sector = SEC_B_R;
            base   = 9'd240;
        end
        else
        begin
            sector = SEC_R_B;
            base   = 9'd300;
        end
    end

    // The offset in the sector is 0..59, or 60 at hue 360. The secondary rises
    // through even sectors and falls through odd ones.
    always_comb
    begin
        offset     = WT_W'(hue_sat - base);
        odd_sector = (sector == SEC_G_R) || (sector == SEC_B_G) || (sector == SEC_R_B);

        item_next.lamp_on  = lamp_on;
        item_next.sat      = sat_sat;
        item_next.bright   = bright_sat;
        item_next.weight   = odd_sector ? (WT_W'(SECTOR_DEG) - offset) : offset;
        item_next.sector   = sector;
    end

    // One holding register; it takes a new request whenever it empties.
    assign push_valid = vld_reg;
    assign push_item  = item_reg;
    assign item_ready = !vld_reg || push_ready;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        vld_next = take || (vld_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: design/hrgb_queue.sv
// ----------------------------------------------------------------------------
// hrgb_queue
// Short first-in first-out queue of classified requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
module hrgb_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  hrgb_pkg::work_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output hrgb_pkg::work_t pop_item
);
    import hrgb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    work_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage of the queued requests.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    // Pointers are equal when the queue is empty or full.
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

    // A push into an empty queue makes it nonempty at the next edge.
    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop_valid) |=> pop_valid)
        else $error("queue lost a pushed request");

endmodule

// File: design/hrgb_back.sv
// ----------------------------------------------------------------------------
// hrgb_back
// Arithmetic pipeline: chroma, secondary and offset, channel assignment by
// sector, and scaling of each channel to an 8-bit drive level.
// ----------------------------------------------------------------------------
module hrgb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  hrgb_pkg::work_t                pop_item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [hrgb_pkg::LEVEL_W-1:0]   red_level,
    output logic [hrgb_pkg::LEVEL_W-1:0]   green_level,
    output logic [hrgb_pkg::LEVEL_W-1:0]   blue_level
);
    import hrgb_pkg::*;

    logic                en;

    // Stage 1: V*S.
    logic                s1_vld_reg;
    logic                s1_pw_reg;
    logic [PCT_W-1:0]    s1_v_reg;
    logic [VS_W-1:0]     s1_vs_reg;
    logic [WT_W-1:0]     s1_w_reg;
    sector_t             s1_sec_reg;

    // Stage 2: C, X and m.
    logic                s2_vld_reg;
    logic                s2_pw_reg;
    logic [SCALE_W-1:0]  s2_c_reg;
    logic [SCALE_W-1:0]  s2_x_reg;
    logic [SCALE_W-1:0]  s2_m_reg;
    sector_t             s2_sec_reg;
    logic [SCALE_W-1:0]  c_next;

    // Stage 3: per-channel value times 17, divided by 64.
    logic                s3_vld_reg;
    logic                s3_pw_reg;
    logic [DIV_W-1:0]    s3_r_reg;
    logic [DIV_W-1:0]    s3_g_reg;
    logic [DIV_W-1:0]    s3_b_reg;
    logic [SCALE_W-1:0]  rs;
    logic [SCALE_W-1:0]  gs;
    logic [SCALE_W-1:0]  bs;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   g_prod;
    logic [PROD_W-1:0]   b_prod;

    // Output stage: division by 625 through the reciprocal.
    logic                out_vld_reg;
    logic                out_pw_reg;
    logic [LEVEL_W-1:0]  red_reg;
    logic [LEVEL_W-1:0]  green_reg;
    logic [LEVEL_W-1:0]  blue_reg;
    logic [QPROD_W-1:0]  r_q;
    logic [QPROD_W-1:0]  g_q;
    logic [QPROD_W-1:0]  b_q;

    // The whole pipeline advances while the output register is free or taken.
    assign en        = !out_vld_reg || result_ready;
    assign pop_ready = en;

    assign result_valid = out_vld_reg;
    assign red_level    = red_reg;
    assign green_level  = green_reg;
    assign blue_level   = blue_reg;

    // Chroma, reused for the offset.
    assign c_next = SCALE_W'(s1_vs_reg) * SECTOR_DEG;

    // Route chroma and secondary to the channels of the sector.
    always_comb
    begin
        unique case (s2_sec_reg)
            SEC_R_G:
            begin
                rs = s2_c_reg; gs = s2_x_reg; bs = '0;
            end
            SEC_G_R:
            begin
                rs = s2_x_reg; gs = s2_c_reg; bs = '0;
            end
            SEC_G_B:
            begin
                rs = '0; gs = s2_c_reg; bs = s2_x_reg;
            end
            SEC_B_G:
            begin
                rs = '0; gs = s2_x_reg; bs = s2_c_reg;
            end
            SEC_B_R:
            begin
                rs = s2_x_reg; gs = '0; bs = s2_c_reg;
            end
            SEC_R_B:
            begin
                rs = s2_c_reg; gs = '0; bs = s2_x_reg;
            end
            default:
            begin
                rs = '0; gs = '0; bs = '0;
            end
        endcase
        r_prod = PROD_W'(rs + s2_m_reg) * LEVEL_MUL;
        g_prod = PROD_W'(gs + s2_m_reg) * LEVEL_MUL;
        b_prod = PROD_W'(bs + s2_m_reg) * LEVEL_MUL;
    end

    // Reciprocal multiply; the quotient is at most 255.
    always_comb
    begin
        r_q = QPROD_W'(s3_r_reg) * QPROD_W'(RECIP_625);
        g_q = QPROD_W'(s3_g_reg) * QPROD_W'(RECIP_625);
        b_q = QPROD_W'(s3_b_reg) * QPROD_W'(RECIP_625);
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= pop_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pw_reg  <= pop_item.lamp_on;
            s1_v_reg   <= pop_item.bright;
            s1_vs_reg  <= VS_W'(pop_item.bright) * VS_W'(pop_item.sat);
            s1_w_reg   <= pop_item.weight;
            s1_sec_reg <= pop_item.sector;

            s2_pw_reg  <= s1_pw_reg;
            s2_c_reg   <= c_next;
            s2_x_reg   <= SCALE_W'(s1_vs_reg) * SCALE_W'(s1_w_reg);
            s2_m_reg   <= SCALE_W'(s1_v_reg) * V_SCALE - c_next;
            s2_sec_reg <= s1_sec_reg;

            s3_pw_reg  <= s2_pw_reg;
            s3_r_reg   <= r_prod[PRE_SHIFT +: DIV_W];
            s3_g_reg   <= g_prod[PRE_SHIFT +: DIV_W];
            s3_b_reg   <= b_prod[PRE_SHIFT +: DIV_W];

            out_pw_reg <= s3_pw_reg;
            red_reg    <= s3_pw_reg ? r_q[RECIP_SHIFT +: LEVEL_W] : '0;
            green_reg  <= s3_pw_reg ? g_q[RECIP_SHIFT +: LEVEL_W] : '0;
            blue_reg   <= s3_pw_reg ? b_q[RECIP_SHIFT +: LEVEL_W] : '0;
        end
    end

    // A lamp that is off always shows black.
    a_black_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_pw_reg) |->
            (red_reg == '0 && green_reg == '0 && blue_reg == '0))
        else $error("power-off request gave a nonzero level");

    // A request in the last stage reaches the output when the pipeline moves.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_vld_reg && en) |=> out_vld_reg)
        else $error("request lost between last stage and output");

    // A stalled pipeline holds its last stage.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && s3_vld_reg) |=> (s3_vld_reg && $stable(s3_r_reg)))
        else $error("last stage changed during a stall");

endmodule

// File: design/hsv_to_rgb_led_color.sv
// Throughput: one request per cycle while result_ready does not stall it;
// the result pipeline is four stages behind a QUEUE_DEPTH-entry queue and
// stalls as one on the result side. Reset clears only the valid bits,
// queue pointers and fill count; the data registers and queue storage are
// not reset, and the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_color
// Converts a power flag, hue, saturation and brightness into 8-bit red,
// green and blue drive levels with exact integer arithmetic.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_color #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic                           lamp_on,
    input  logic [hrgb_pkg::HUE_W-1:0]     hue_deg,
    input  logic [hrgb_pkg::PCT_W-1:0]     saturation_pct,
    input  logic [hrgb_pkg::PCT_W-1:0]     brightness_pct,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [hrgb_pkg::LEVEL_W-1:0]   red_level,
    output logic [hrgb_pkg::LEVEL_W-1:0]   green_level,
    output logic [hrgb_pkg::LEVEL_W-1:0]   blue_level
);
    import hrgb_pkg::*;

    logic  push_valid;
    logic  push_ready;
    work_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    work_t pop_item;

    // Front end: saturate and classify.
    hrgb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .lamp_on        (lamp_on),
        .hue_deg        (hue_deg),
        .saturation_pct (saturation_pct),
        .brightness_pct (brightness_pct),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    // Decoupling queue.
    hrgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back end: arithmetic and scaling.
    hrgb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level)
    );

endmodule
